/* hdl/spo2_ratio_of_ratios_unit_macros.svh */
// Assertion macros shared by the checker of the saturation unit.
`ifndef SPO2_RATIO_OF_RATIOS_UNIT_MACROS_SVH
`define SPO2_RATIO_OF_RATIOS_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SPO2_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spo2 checker: same-cycle property failed");

// Next-cycle implication, switched off while reset is high.
`define SPO2_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spo2 checker: next-cycle property failed");

// What must hold in the cycle after reset has been sampled high.
`define SPO2_ASSERT_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("spo2 checker: reset property failed");

`endif

/* hdl/spo2_pkg.sv */
// Package of the saturation unit: widths, codes, reset values and control structs.
`default_nettype none
package spo2_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COEF_W          = 16;
  localparam int RATIO_W         = 24;
  localparam int FRAC_W          = 16;
  localparam int INDEX_W         = 16;
  localparam int STATUS_W        = 2;
  localparam int MUL_W           = COEF_W + RATIO_W;
  localparam int ACC_W           = COEF_W + RATIO_W + 2;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_HB_RED   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_HB_NIR   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_OXY_RED  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_OXY_NIR  = 3'd4;

  localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 16'd250;
  localparam logic [COEF_W-1:0]     COEF_HB_RED_RESET   = 16'd15000;
  localparam logic [COEF_W-1:0]     COEF_HB_NIR_RESET   = 16'd2409;
  localparam logic [COEF_W-1:0]     COEF_OXY_RED_RESET  = 16'd1472;
  localparam logic [COEF_W-1:0]     COEF_OXY_NIR_RESET  = 16'd4816;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_CLAMPED = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic take;
    logic set_invalid;
    logic mul_a;
    logic mul_b;
    logic div_ratio;
    logic clip;
    logic mul_n;
    logic mul_d;
    logic form;
    logic norm;
    logic div_sat;
    logic clamp_low;
    logic clamp_high;
    logic finish_sat;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close;
    logic invalid;
    logic div_busy;
    logic den_zero;
    logic num_pos;
    logic num_neg;
    logic num_ge_den;
  } dp_status_t;

endpackage
`default_nettype wire

/* hdl/spo2_channels.sv */
// Channel interfaces of the saturation unit: samples in, readings out, register writes.
`default_nettype none
interface spo2_sample_if #(parameter int SAMPLE_BITS = spo2_pkg::SAMPLE_BITS_DEF);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red_sample;
  logic [SAMPLE_BITS-1:0] nir_sample;

  modport source (output valid, output red_sample, output nir_sample, input ready);
  modport sink   (input valid, input red_sample, input nir_sample, output ready);
endinterface

interface spo2_reading_if;
  import spo2_pkg::*;
  logic                valid;
  logic                ready;
  logic [FRAC_W-1:0]   saturation;
  logic [RATIO_W-1:0]  ratio;
  logic [INDEX_W-1:0]  reading_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output saturation, output ratio, output reading_index,
                  output status, input ready);
  modport sink   (input valid, input saturation, input ratio, input reading_index,
                  input status, output ready);
endinterface

interface spo2_cfg_if;
  import spo2_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/spo2_div.sv */
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
module spo2_div #(
  parameter int QW = 2 * spo2_pkg::SAMPLE_BITS_DEF + spo2_pkg::FRAC_W,
  localparam int CW = $clog2(QW + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spo2_pkg::ACC_W-1:0] rem_init,
  input  logic [QW-1:0]              quo_init,
  input  logic [spo2_pkg::ACC_W-1:0] divisor,
  input  logic [CW-1:0]              steps,
  output logic                       busy,
  output logic [QW-1:0]              quo
);
  import spo2_pkg::*;

  logic [ACC_W-1:0] rem;
  logic [ACC_W-1:0] den;
  logic [ACC_W-1:0] trial;
  logic [CW-1:0]    count;
  logic             ge;

  assign trial = {rem[ACC_W-2:0], quo[QW-1]};
  assign ge    = (trial >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= steps;
    end else if (busy) begin
      count <= count - CW'(1);
      busy  <= (count != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      quo <= quo_init;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? (trial - den) : trial;
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* hdl/spo2_dpath.sv */
// Datapath: window trackers, configuration registers, products, formula terms and results.
`default_nettype none
module spo2_dpath #(
  parameter int SAMPLE_BITS = spo2_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spo2_pkg::ctrl_cmd_t              cmd,
  output spo2_pkg::dp_status_t             st,
  input  logic [SAMPLE_BITS-1:0]           red_sample,
  input  logic [SAMPLE_BITS-1:0]           nir_sample,
  input  logic                             cfg_write,
  input  logic [spo2_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spo2_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [spo2_pkg::FRAC_W-1:0]      saturation,
  output logic [spo2_pkg::RATIO_W-1:0]     ratio,
  output logic [spo2_pkg::INDEX_W-1:0]     reading_index,
  output logic [spo2_pkg::STATUS_W-1:0]    status
);
  import spo2_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int QW     = PROD_W + FRAC_W;
  localparam int CW     = $clog2(QW + 1);

  logic [CFG_DATA_W-1:0] window_length;
  logic [COEF_W-1:0]     coef_hb_red;
  logic [COEF_W-1:0]     coef_hb_nir;
  logic [COEF_W-1:0]     coef_oxy_red;
  logic [COEF_W-1:0]     coef_oxy_nir;

  logic [INDEX_W-1:0]     sample_count;
  logic [INDEX_W-1:0]     count_inc;
  logic [SAMPLE_BITS-1:0] red_peak, red_floor, nir_peak, nir_floor;
  logic [SAMPLE_BITS-1:0] red_peak_next, red_floor_next, nir_peak_next, nir_floor_next;
  logic [INDEX_W-1:0]     reading_count;

  logic [SAMPLE_BITS-1:0] snap_red_peak, snap_red_floor, snap_nir_peak, snap_nir_floor;
  logic [INDEX_W-1:0]     snap_index;
  logic [SAMPLE_BITS-1:0] red_span, nir_span;
  logic [PROD_W-1:0]      a_prod, b_prod;

  logic [FRAC_W-1:0]      res_sat;
  logic [RATIO_W-1:0]     res_ratio;
  status_t                res_status;
  logic [RATIO_W-1:0]     ratio_clip;

  logic [MUL_W-1:0]        p1;
  logic signed [ACC_W-1:0] p2;
  logic signed [COEF_W:0]  red_gap, nir_gap;
  logic signed [ACC_W-1:0] hr_shift, gap_shift;
  logic signed [ACC_W-1:0] num, den;

  logic             div_start;
  logic [ACC_W-1:0] div_rem_init;
  logic [QW-1:0]    div_quo_init;
  logic [ACC_W-1:0] div_divisor;
  logic [CW-1:0]    div_steps;
  logic             div_busy;
  logic [QW-1:0]    div_quo;

  assign count_inc      = sample_count + INDEX_W'(1);
  assign red_peak_next  = (red_sample > red_peak)  ? red_sample : red_peak;
  assign red_floor_next = (red_sample < red_floor) ? red_sample : red_floor;
  assign nir_peak_next  = (nir_sample > nir_peak)  ? nir_sample : nir_peak;
  assign nir_floor_next = (nir_sample < nir_floor) ? nir_sample : nir_floor;

  assign st.close      = (count_inc >= window_length);
  assign st.invalid    = (snap_red_floor == '0) || (snap_nir_floor == '0) ||
                         (snap_nir_peak == snap_nir_floor);
  assign st.div_busy   = div_busy;
  assign st.den_zero   = (den == '0);
  assign st.num_neg    = num[ACC_W-1];
  assign st.num_pos    = !num[ACC_W-1] && (num != '0);
  assign st.num_ge_den = (num >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      coef_hb_red   <= COEF_HB_RED_RESET;
      coef_hb_nir   <= COEF_HB_NIR_RESET;
      coef_oxy_red  <= COEF_OXY_RED_RESET;
      coef_oxy_nir  <= COEF_OXY_NIR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_COEF_HB_RED:   coef_hb_red   <= cfg_data;
        REG_COEF_HB_NIR:   coef_hb_nir   <= cfg_data;
        REG_COEF_OXY_RED:  coef_oxy_red  <= cfg_data;
        REG_COEF_OXY_NIR:  coef_oxy_nir  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Trackers restart on the sample that closes the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      red_peak      <= '0;
      red_floor     <= '1;
      nir_peak      <= '0;
      nir_floor     <= '1;
      reading_count <= '0;
    end else if (cmd.take) begin
      if (st.close) begin
        sample_count  <= '0;
        red_peak      <= '0;
        red_floor     <= '1;
        nir_peak      <= '0;
        nir_floor     <= '1;
        reading_count <= reading_count + INDEX_W'(1);
      end else begin
        sample_count <= count_inc;
        red_peak     <= red_peak_next;
        red_floor    <= red_floor_next;
        nir_peak     <= nir_peak_next;
        nir_floor    <= nir_floor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && st.close) begin
      snap_red_peak  <= red_peak_next;
      snap_red_floor <= red_floor_next;
      snap_nir_peak  <= nir_peak_next;
      snap_nir_floor <= nir_floor_next;
      snap_index     <= reading_count;
    end
  end

  assign red_span = snap_red_peak - snap_red_floor;
  assign nir_span = snap_nir_peak - snap_nir_floor;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      a_prod <= PROD_W'(red_span) * PROD_W'(snap_nir_floor);
    end
    if (cmd.mul_b) begin
      b_prod <= PROD_W'(snap_red_floor) * PROD_W'(nir_span);
    end
  end

  assign div_start    = cmd.div_ratio || cmd.div_sat;
  assign div_rem_init = cmd.div_sat ? $unsigned(num) : '0;
  assign div_quo_init = cmd.div_sat ? '0 : {a_prod, {FRAC_W{1'b0}}};
  assign div_divisor  = cmd.div_sat ? $unsigned(den) : ACC_W'(b_prod);
  assign div_steps    = cmd.div_sat ? CW'(FRAC_W) : CW'(QW);

  spo2_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  assign ratio_clip = (|div_quo[QW-1:RATIO_W]) ? '1 : div_quo[RATIO_W-1:0];

  assign red_gap   = $signed({1'b0, coef_hb_red}) - $signed({1'b0, coef_oxy_red});
  assign nir_gap   = $signed({1'b0, coef_hb_nir}) - $signed({1'b0, coef_oxy_nir});
  assign hr_shift  = $signed(ACC_W'({coef_hb_red, {FRAC_W{1'b0}}}));
  assign gap_shift = ACC_W'($signed({red_gap, {FRAC_W{1'b0}}}));

  always_ff @(posedge clk) begin
    if (cmd.mul_n) begin
      p1 <= MUL_W'(coef_hb_nir) * MUL_W'(res_ratio);
    end
    if (cmd.mul_d) begin
      p2 <= nir_gap * $signed({1'b0, res_ratio});
    end
    if (cmd.form) begin
      num <= hr_shift - $signed(ACC_W'(p1));
      den <= gap_shift - p2;
    end else if (cmd.norm && den[ACC_W-1]) begin
      num <= -num;
      den <= -den;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_invalid) begin
      res_sat    <= '0;
      res_ratio  <= '0;
      res_status <= STATUS_INVALID;
    end
    if (cmd.clip) begin
      res_ratio <= ratio_clip;
    end
    if (cmd.clamp_low) begin
      res_sat    <= '0;
      res_status <= STATUS_CLAMPED;
    end
    if (cmd.clamp_high) begin
      res_sat    <= '1;
      res_status <= STATUS_CLAMPED;
    end
    if (cmd.finish_sat) begin
      res_sat    <= div_quo[FRAC_W-1:0];
      res_status <= STATUS_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      saturation    <= res_sat;
      ratio         <= res_ratio;
      reading_index <= snap_index;
      status        <= res_status;
    end
  end

endmodule
`default_nettype wire

/* hdl/spo2_ctrl.sv */
// Controller: sequences sample intake and the reading computation, and owns the output valid.
`default_nettype none
module spo2_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  spo2_pkg::dp_status_t st,
  output spo2_pkg::ctrl_cmd_t  cmd
);
  import spo2_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'h0001,
    ST_CHECK   = 15'h0002,
    ST_MUL_A   = 15'h0004,
    ST_MUL_B   = 15'h0008,
    ST_START_R = 15'h0010,
    ST_DIV_R   = 15'h0020,
    ST_CLIP    = 15'h0040,
    ST_MUL_N   = 15'h0080,
    ST_MUL_D   = 15'h0100,
    ST_FORM    = 15'h0200,
    ST_NORM    = 15'h0400,
    ST_DECIDE  = 15'h0800,
    ST_DIV_S   = 15'h1000,
    ST_DONE    = 15'h2000,
    ST_SPARE   = 15'h4000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.close) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (st.invalid) begin
          cmd.set_invalid = 1'b1;
          state_next      = ST_DONE;
        end else begin
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_START_R;
      end
      ST_START_R: begin
        cmd.div_ratio = 1'b1;
        state_next    = ST_DIV_R;
      end
      ST_DIV_R: begin
        if (!st.div_busy) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = ST_MUL_N;
      end
      ST_MUL_N: begin
        cmd.mul_n  = 1'b1;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d  = 1'b1;
        state_next = ST_FORM;
      end
      ST_FORM: begin
        cmd.form   = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (st.den_zero) begin
          cmd.clamp_high = st.num_pos;
          cmd.clamp_low  = !st.num_pos;
          state_next     = ST_DONE;
        end else begin
          cmd.norm   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (st.num_neg) begin
          cmd.clamp_low = 1'b1;
          state_next    = ST_DONE;
        end else if (st.num_ge_den) begin
          cmd.clamp_high = 1'b1;
          state_next     = ST_DONE;
        end else begin
          cmd.div_sat = 1'b1;
          state_next  = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        if (!st.div_busy) begin
          cmd.finish_sat = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/spo2_ratio_of_ratios_unit.sv */
// Top level of the ratio-of-ratios oxygen saturation unit.
//
//   channel   dir  payload                                         transaction when
//   sample    in   red_sample, nir_sample                           valid && ready
//   reading   out  saturation, ratio, reading_index, status         valid && ready
//   cfg       in   index, data                                      valid && ready
//
// A sample that does not close the window is taken and the unit stays ready for the next.
// A closing sample starts a reading computed on the shared divider, which resolves
// one quotient bit per cycle (ratio, then saturation fraction); no sample is taken until it is finished.
// A finished reading waits in the output register; samples are taken meanwhile,
// and the next reading stalls only if it is ready before that register empties.
// Synchronous reset; no clearing pass. Configuration writes are always taken.
`default_nettype none
module spo2_ratio_of_ratios_unit #(
  parameter int SAMPLE_BITS = spo2_pkg::SAMPLE_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  spo2_sample_if.sink   sample,
  spo2_reading_if.source reading,
  spo2_cfg_if.sink      cfg
);
  import spo2_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg.ready = 1'b1;

  spo2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (reading.valid),
    .out_ready (reading.ready),
    .st        (st),
    .cmd       (cmd)
  );

  spo2_dpath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .red_sample    (sample.red_sample),
    .nir_sample    (sample.nir_sample),
    .cfg_write     (cfg.valid && cfg.ready),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .saturation    (reading.saturation),
    .ratio         (reading.ratio),
    .reading_index (reading.reading_index),
    .status        (reading.status)
  );

endmodule
`default_nettype wire

/* hdl/spo2_checker.sv */
// Port-level checker for the saturation unit and its bind to the top level.
`default_nettype none
`include "spo2_ratio_of_ratios_unit_macros.svh"
module spo2_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spo2_pkg::FRAC_W-1:0]   out_saturation,
  input logic [spo2_pkg::RATIO_W-1:0]  out_ratio,
  input logic [spo2_pkg::INDEX_W-1:0]  out_reading_index,
  input logic [spo2_pkg::STATUS_W-1:0] out_status
);
  import spo2_pkg::*;

  // A stalled reading keeps its contents.
  `SPO2_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_saturation) && $stable(out_ratio) && $stable(out_reading_index) && $stable(out_status))

  // An invalid reading carries neither a ratio nor a saturation.
  `SPO2_ASSERT_IMPLIES(a_invalid_zero, clk, rst, out_valid && (out_status == STATUS_INVALID), (out_saturation == '0) && (out_ratio == '0))

  // A reading never appears directly after a sample transaction.
  `SPO2_ASSERT_IMPLIES(a_no_early, clk, rst, $rose(out_valid), !$past(in_valid && in_ready))

  // Reset leaves no reading pending.
  `SPO2_ASSERT_RESET(a_reset_empty, clk, rst, !out_valid)

endmodule

bind spo2_ratio_of_ratios_unit spo2_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (sample.valid),
  .in_ready          (sample.ready),
  .out_valid         (reading.valid),
  .out_ready         (reading.ready),
  .out_saturation    (reading.saturation),
  .out_ratio         (reading.ratio),
  .out_reading_index (reading.reading_index),
  .out_status        (reading.status)
);
`default_nettype wire
